/* hw/rtl/g2e_pkg.sv */
// ----------------------------------------------------------------------------
// g2e_pkg: galactic to equatorial conversion package
// Types, constants and arithmetic helpers shared by the conversion datapath.
// ----------------------------------------------------------------------------
package g2e_pkg;

    localparam int ANGLE_BITS = 16;

    localparam logic [31:0] GAIN_Q30  = 32'd652032874;
    localparam logic [31:0] RA_NGP    = 32'd2300790120;
    localparam logic [31:0] DEC_NGP   = 32'd323673508;
    localparam logic [31:0] L_NCP     = 32'd1467447159;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [33:0] QUARTER = 34'sd1073741824;

    typedef struct packed {
        logic [15:0]        gal_longitude;
        logic signed [15:0] gal_latitude;
    } t_in;

    typedef struct packed {
        logic [15:0]        right_ascension;
        logic signed [15:0] declination;
    } t_out;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } t_rot_lane;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic [31:0]        z;
    } t_vec;

    function automatic logic [31:0] atan_ang(input int unsigned i);
        logic [31:0] v;
        case (i)
            0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
            3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
            9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
            15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
            21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
            24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
            27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // range reduction into the cordic rotation domain
    function automatic t_rot_lane rot_init(input logic [31:0] a);
        t_rot_lane   r;
        logic [31:0] a2;
        r.x    = 34'(signed'({2'b00, GAIN_Q30}));
        r.y    = '0;
        r.z    = {{2{a[31]}}, a};
        r.flip = 1'b0;
        if (r.z > QUARTER || r.z < -QUARTER) begin
            a2     = a + HALF_TURN;
            r.z    = {{2{a2[31]}}, a2};
            r.flip = 1'b1;
        end
        return r;
    endfunction

    // rounded q30 product
    function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + (64'sd1 <<< 29);
        return p[63:30];
    endfunction

    // elaboration-time sine or cosine of a constant angle
    function automatic logic signed [63:0] const_trig(input logic [31:0] a,
                                                      input int n,
                                                      input bit want_cos);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [31:0]        a2;
        logic               flip;
        x    = 64'(signed'({1'b0, GAIN_Q30}));
        y    = '0;
        z    = {{32{a[31]}}, a};
        flip = 1'b0;
        if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
            a2   = a + HALF_TURN;
            z    = {{32{a2[31]}}, a2};
            flip = 1'b1;
        end
        for (int i = 0; i < 32; i++) begin
            if (i < n) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - 64'(atan_ang(i));
                end else begin
                    x = x + dx; y = y - dy; z = z + 64'(atan_ang(i));
                end
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        return want_cos ? x : y;
    endfunction

endpackage

/* hw/rtl/g2e_rot_cell.sv */
// ----------------------------------------------------------------------------
// g2e_rot_cell: rotation cordic cell
// One micro-rotation on the latitude lane and the longitude lane per cycle while i_en is high.
// ----------------------------------------------------------------------------
module g2e_rot_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  g2e_pkg::t_rot_lane  i_b,
    input  g2e_pkg::t_rot_lane  i_l,
    output logic                o_vld,
    output g2e_pkg::t_rot_lane  o_b,
    output g2e_pkg::t_rot_lane  o_l
);

    localparam logic signed [33:0] ATAN = 34'(g2e_pkg::atan_ang(IDX));

    logic               r_vld;
    g2e_pkg::t_rot_lane r_b;
    g2e_pkg::t_rot_lane r_l;
    g2e_pkg::t_rot_lane n_b;
    g2e_pkg::t_rot_lane n_l;

    function automatic g2e_pkg::t_rot_lane step(input g2e_pkg::t_rot_lane a);
        g2e_pkg::t_rot_lane r;
        r = a;
        if (a.z >= 0) begin
            r.x = a.x - (a.y >>> IDX);
            r.y = a.y + (a.x >>> IDX);
            r.z = a.z - ATAN;
        end else begin
            r.x = a.x + (a.y >>> IDX);
            r.y = a.y - (a.x >>> IDX);
            r.z = a.z + ATAN;
        end
        return r;
    endfunction

    always_comb begin
        n_b = step(i_b);
        n_l = step(i_l);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_b <= n_b;
            r_l <= n_l;
        end
    end

    assign o_vld = r_vld;
    assign o_b   = r_b;
    assign o_l   = r_l;

endmodule

/* hw/rtl/g2e_vec_cell.sv */
// ----------------------------------------------------------------------------
// g2e_vec_cell: vectoring cordic cell
// One micro-rotation toward the x axis per cycle while i_en is high, side data rides along.
// ----------------------------------------------------------------------------
module g2e_vec_cell #(
    parameter int IDX = 0,
    parameter int SW  = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  g2e_pkg::t_vec   i_d,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output g2e_pkg::t_vec   o_d,
    output logic [SW-1:0]   o_side
);

    localparam logic [31:0] ATAN = g2e_pkg::atan_ang(IDX);

    logic            r_vld;
    g2e_pkg::t_vec   r_d;
    logic [SW-1:0]   r_side;
    g2e_pkg::t_vec   n_d;

    always_comb begin
        if (i_d.y > 0) begin
            n_d.x = i_d.x + (i_d.y >>> IDX);
            n_d.y = i_d.y - (i_d.x >>> IDX);
            n_d.z = i_d.z + ATAN;
        end else begin
            n_d.x = i_d.x - (i_d.y >>> IDX);
            n_d.y = i_d.y + (i_d.x >>> IDX);
            n_d.z = i_d.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_d    <= n_d;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_d    = r_d;
    assign o_side = r_side;

endmodule

/* hw/rtl/galactic_to_equatorial_unit.sv */
// ----------------------------------------------------------------------------
// galactic_to_equatorial_unit: galactic to equatorial coordinates (j2000)
// Chains of cordic cells for sin/cos, the ra terms and the final angles.
//
//   channel | direction | beat          | handshake
//   --------+-----------+---------------+-------------------
//   input   | in        | l, b          | i_valid / o_stall
//   output  | out       | ra, dec       | o_valid / i_stall
//
// one beat per cycle sustained while the output is not stalled; the pipeline
// is three cordic chains of ANGLE_BITS cells plus three multiply stages and the
// output register. reset clears valid bits only. a stalled output freezes the
// whole pipeline, so o_stall follows i_stall while an output beat is held.
// ----------------------------------------------------------------------------
module galactic_to_equatorial_unit #(
    parameter int ANGLE_BITS = g2e_pkg::ANGLE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  g2e_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output g2e_pkg::t_out o_data
);

    localparam int N = ANGLE_BITS;
    localparam int P = (N > 16) ? 16 : N;
    localparam logic [31:0] QMASK = 32'hFFFF_FFFF << (32 - N);
    localparam logic signed [63:0] SDP64 = g2e_pkg::const_trig(g2e_pkg::DEC_NGP, N, 1'b0);
    localparam logic signed [63:0] CDP64 = g2e_pkg::const_trig(g2e_pkg::DEC_NGP, N, 1'b1);
    localparam logic signed [31:0] SDP = SDP64[31:0];
    localparam logic signed [31:0] CDP = CDP64[31:0];
    localparam logic signed [34:0] GAIN_S = 35'(g2e_pkg::GAIN_Q30);
    localparam logic [32:0] RND = 33'd1 << (31 - P);

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // input range reduction
    logic [31:0] qb;
    logic [31:0] ql;
    assign qb = {i_data.gal_latitude, 16'h0000} & QMASK;
    assign ql = ({i_data.gal_longitude, 16'h0000} & QMASK) - g2e_pkg::L_NCP;

    // rotation chain
    logic               rv [0:N];
    g2e_pkg::t_rot_lane rb [0:N];
    g2e_pkg::t_rot_lane rl [0:N];
    assign rv[0] = i_valid;
    assign rb[0] = g2e_pkg::rot_init(qb);
    assign rl[0] = g2e_pkg::rot_init(ql);

    for (genvar i = 0; i < N; i++) begin : g_rot
        g2e_rot_cell #(.IDX(i)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vld(rv[i]), .i_b(rb[i]), .i_l(rl[i]),
            .o_vld(rv[i+1]), .o_b(rb[i+1]), .o_l(rl[i+1])
        );
    end

    // sines and cosines after the half-turn fold
    logic signed [33:0] sb_w;
    logic signed [33:0] cb_w;
    logic signed [33:0] sdl_w;
    logic signed [33:0] cdl_w;
    assign sb_w  = rb[N].flip ? -rb[N].y : rb[N].y;
    assign cb_w  = rb[N].flip ? -rb[N].x : rb[N].x;
    assign sdl_w = rl[N].flip ? -rl[N].y : rl[N].y;
    assign cdl_w = rl[N].flip ? -rl[N].x : rl[N].x;

    // first product stage
    logic               r_m1_vld;
    logic signed [33:0] r_cbc;
    logic signed [33:0] r_p_sb;
    logic signed [33:0] r_p_cbsdl;
    logic signed [33:0] r_p_sbcdp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (en) begin
            r_m1_vld <= rv[N];
        end
        if (en) begin
            r_cbc     <= g2e_pkg::mulq(cb_w[31:0], cdl_w[31:0]);
            r_p_sb    <= g2e_pkg::mulq(SDP, sb_w[31:0]);
            r_p_cbsdl <= g2e_pkg::mulq(cb_w[31:0], sdl_w[31:0]);
            r_p_sbcdp <= g2e_pkg::mulq(sb_w[31:0], CDP);
        end
    end

    // second product stage: sine term and the two ra terms
    logic               r_m2_vld;
    logic signed [34:0] r_s;
    logic signed [34:0] r_xs;
    logic signed [34:0] r_ys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (en) begin
            r_m2_vld <= r_m1_vld;
        end
        if (en) begin
            r_s  <= 35'(r_p_sb) + 35'(g2e_pkg::mulq(CDP, r_cbc[31:0]));
            r_xs <= 35'(r_p_sbcdp) - 35'(g2e_pkg::mulq(SDP, r_cbc[31:0]));
            r_ys <= -35'(r_p_cbsdl);
        end
    end

    // ra vectoring chain
    logic          v1v [0:N];
    g2e_pkg::t_vec v1d [0:N];
    logic [35:0]   v1s [0:N];
    assign v1v[0] = r_m2_vld;
    assign v1s[0] = {(r_xs == '0) && (r_ys == '0), r_s};
    always_comb begin
        if (r_xs < 0) begin
            v1d[0].x = -r_xs;
            v1d[0].y = -r_ys;
            v1d[0].z = g2e_pkg::HALF_TURN;
        end else begin
            v1d[0].x = r_xs;
            v1d[0].y = r_ys;
            v1d[0].z = '0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_vec1
        g2e_vec_cell #(.IDX(i), .SW(36)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vld(v1v[i]), .i_d(v1d[i]), .i_side(v1s[i]),
            .o_vld(v1v[i+1]), .o_d(v1d[i+1]), .o_side(v1s[i+1])
        );
    end

    // gain correction of the cos(dec) magnitude
    logic               r_m3_vld;
    logic signed [34:0] r_r;
    logic signed [34:0] r_s3;
    logic [31:0]        r_dra;
    logic signed [69:0] pr;
    assign pr = v1d[N].x * GAIN_S + (70'sd1 <<< 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else if (en) begin
            r_m3_vld <= v1v[N];
        end
        if (en) begin
            r_s3  <= v1s[N][34:0];
            r_r   <= v1s[N][35] ? '0 : pr[64:30];
            r_dra <= v1s[N][35] ? '0 : v1d[N].z;
        end
    end

    // declination vectoring chain
    logic          v2v [0:N];
    g2e_pkg::t_vec v2d [0:N];
    logic [31:0]   v2s [0:N];
    assign v2v[0] = r_m3_vld;
    assign v2s[0] = r_dra;
    always_comb begin
        if (r_r < 0) begin
            v2d[0].x = -r_r;
            v2d[0].y = -r_s3;
            v2d[0].z = g2e_pkg::HALF_TURN;
        end else begin
            v2d[0].x = r_r;
            v2d[0].y = r_s3;
            v2d[0].z = '0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_vec2
        g2e_vec_cell #(.IDX(i), .SW(32)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vld(v2v[i]), .i_d(v2d[i]), .i_side(v2s[i]),
            .o_vld(v2v[i+1]), .o_d(v2d[i+1]), .o_side(v2s[i+1])
        );
    end

    // saturation, ra offset and rounding to the output field
    logic signed [33:0] dec_w;
    logic [31:0]        dec_a;
    logic [31:0]        ra_a;
    logic [32:0]        dec_r;
    logic [32:0]        ra_r;
    logic [15:0]        dec_f;
    logic [15:0]        ra_f;

    always_comb begin
        dec_w = {{2{v2d[N].z[31]}}, v2d[N].z};
        if (dec_w > g2e_pkg::QUARTER) begin
            dec_w = g2e_pkg::QUARTER;
        end
        if (dec_w < -g2e_pkg::QUARTER) begin
            dec_w = -g2e_pkg::QUARTER;
        end
        dec_a = dec_w[31:0];
        ra_a  = g2e_pkg::RA_NGP + v2s[N];
        dec_r = (({1'b0, dec_a} + RND) >> (32 - P)) << (16 - P);
        ra_r  = (({1'b0, ra_a} + RND) >> (32 - P)) << (16 - P);
        dec_f = dec_r[15:0];
        ra_f  = ra_r[15:0];
    end

    logic          r_out_vld;
    g2e_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= v2v[N];
        end
        if (en) begin
            r_out.right_ascension <= ra_f;
            r_out.declination     <= dec_f;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

/* hw/rtl/g2e_checker.sv */
// ----------------------------------------------------------------------------
// g2e_checker: port checks for the conversion unit
// Watches the top-level ports over time; attached with a bind.
// ----------------------------------------------------------------------------
module g2e_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input g2e_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input g2e_pkg::t_out o_data
);

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_no_needless_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    a_dec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.declination <= 16'sd16384 &&
                     o_data.declination >= -16'sd16384))
        else $error("declination beyond a quarter turn");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled output beat changed");

endmodule

bind galactic_to_equatorial_unit g2e_checker u_g2e_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
